>>> rtl/sparse_row_weight_table_unit_assert.svh
// Assertion macros used by the sparse row weight table top-level unit.
`ifndef SPARSE_ROW_WEIGHT_TABLE_UNIT_ASSERT_SVH
`define SPARSE_ROW_WEIGHT_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SRWT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srwt assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SRWT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srwt assertion failed");

`endif

>>> rtl/srwt_pkg.sv
package srwt_pkg;

  localparam int ROWS_DEF         = 32;
  localparam int MAX_CONNS_DEF    = 8;
  localparam int SOURCE_WIDTH_DEF = 10;

  localparam int SRC_IN_W = 10;
  localparam int ROW_IN_W = 5;
  localparam int WEIGHT_W = 32;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_SET    = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic                       command;
    logic [SRC_IN_W-1:0]        source_id;
    logic [ROW_IN_W-1:0]        row_index;
    logic signed [WEIGHT_W-1:0] weight_value;
  } in_word_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight_out;
    logic                       found;
    logic [1:0]                 status;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic search;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic done;
  } dp_stat_t;

endpackage

>>> rtl/sparse_row_weight_table_unit.sv
// Sparse row weight table: each row keeps up to MAX_CONNS (source id, weight)
// slots and a fill count.
// A command word is taken on in_data at a rising edge where start is high and
// busy is low. A lookup returns the weight stored for the source in the row,
// or zero. A set updates the first matching slot or appends a new one, and
// reports a full status, leaving the table alone, for a full or out-of-range row.
// Exactly one result word appears on out_data for a single cycle, marked by
// out_valid. The receiver cannot stall it and must take it in that cycle.
// The row slots are read one per cycle from a single-port slot memory with a
// registered read, and each slot read is compared with the source id. The
// search ends at the first match or when the row's fill count is used up; a
// write-back state follows, and the result strobe is registered from it.
// busy stays high from acceptance through the final write-back cycle, and
// the next word may be accepted while the result is shown.
// Reset clears all fill counts at once, so every row starts empty and the
// block is ready in the first cycle after reset.
module sparse_row_weight_table_unit #(
  parameter int ROWS         = srwt_pkg::ROWS_DEF,
  parameter int MAX_CONNS    = srwt_pkg::MAX_CONNS_DEF,
  parameter int SOURCE_WIDTH = srwt_pkg::SOURCE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  srwt_pkg::in_word_t  in_data,
  output logic                out_valid,
  output srwt_pkg::out_word_t out_data
);

  `include "sparse_row_weight_table_unit_assert.svh"

  srwt_pkg::ctl_cmd_t ctl_cmd;
  srwt_pkg::dp_stat_t dp_stat;
  logic               res_found;
  logic               res_full;

  srwt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (dp_stat),
    .cmd   (ctl_cmd),
    .busy  (busy)
  );

  srwt_dp #(
    .ROWS         (ROWS),
    .MAX_CONNS    (MAX_CONNS),
    .SOURCE_WIDTH (SOURCE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (ctl_cmd),
    .in_data   (in_data),
    .stat      (dp_stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign res_found = out_valid && out_data.found;
  assign res_full  = out_valid && (out_data.status == srwt_pkg::ST_FULL);

  `SRWT_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `SRWT_ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  `SRWT_ASSERT_IMP(a_found_ok, clk, rst_n, res_found, out_data.status == srwt_pkg::ST_OK)
  `SRWT_ASSERT_IMP(a_full_zero, clk, rst_n, res_full, out_data.weight_out == 0)

endmodule

>>> rtl/srwt_ctrl.sv
module srwt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  srwt_pkg::dp_stat_t stat,
  output srwt_pkg::ctl_cmd_t cmd,
  output logic              busy
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign cmd.load   = (state_r == S_IDLE) && start;
  assign cmd.search = (state_r == S_SEARCH);
  assign cmd.finish = (state_r == S_FINISH);

endmodule

>>> rtl/srwt_dp.sv
module srwt_dp #(
  parameter int ROWS         = srwt_pkg::ROWS_DEF,
  parameter int MAX_CONNS    = srwt_pkg::MAX_CONNS_DEF,
  parameter int SOURCE_WIDTH = srwt_pkg::SOURCE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  srwt_pkg::ctl_cmd_t  cmd,
  input  srwt_pkg::in_word_t  in_data,
  output srwt_pkg::dp_stat_t  stat,
  output logic                out_valid,
  output srwt_pkg::out_word_t out_data
);

  localparam int ROW_N  = (ROWS < (1 << srwt_pkg::ROW_IN_W)) ? ROWS : (1 << srwt_pkg::ROW_IN_W);
  localparam int ROW_AW = (ROW_N > 1) ? $clog2(ROW_N) : 1;
  localparam int CNT_W  = $clog2(MAX_CONNS + 1);
  localparam int DEPTH  = ROW_N * MAX_CONNS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KEY_W  = (SOURCE_WIDTH < srwt_pkg::SRC_IN_W) ? SOURCE_WIDTH
                                                              : srwt_pkg::SRC_IN_W;
  localparam int W_W    = srwt_pkg::WEIGHT_W;

  logic [KEY_W-1:0]  id_mem [DEPTH];
  logic [W_W-1:0]    w_mem  [DEPTH];
  logic [CNT_W-1:0]  fill_r [ROW_N];

  logic              cmd_set_r;
  logic [KEY_W-1:0]  key_r;
  logic [ROW_AW-1:0] row_r;
  logic              row_ok_r;
  logic [W_W-1:0]    val_r;
  logic [ADDR_W-1:0] base_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  rd_idx_r;
  logic [CNT_W-1:0]  cmp_idx_r;
  logic              cmp_vld_r;
  logic              hit_r;
  logic [CNT_W-1:0]  hit_idx_r;
  logic [W_W-1:0]    hit_w_r;
  logic [KEY_W-1:0]  rd_id_r;
  logic [W_W-1:0]    rd_w_r;
  logic              out_valid_r;
  srwt_pkg::out_word_t out_word_r;

  logic              in_row_ok;
  logic [ROW_AW-1:0] in_row;
  logic              rd_more;
  logic              hit_now;
  logic              full;
  logic              w_we;
  logic              id_we;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  srwt_pkg::out_word_t out_word_nxt;

  assign in_row_ok = (32'(in_data.row_index) < 32'(ROWS));
  assign in_row    = in_data.row_index[ROW_AW-1:0];
  assign rd_more   = (rd_idx_r != cnt_r);
  assign hit_now   = cmp_vld_r && (rd_id_r == key_r);
  assign stat.done = !rd_more || hit_now;
  assign full      = !row_ok_r || (cnt_r >= CNT_W'(MAX_CONNS));
  assign rd_addr   = base_r + ADDR_W'(rd_idx_r);
  assign wr_addr   = hit_r ? (base_r + ADDR_W'(hit_idx_r)) : (base_r + ADDR_W'(cnt_r));
  assign w_we      = cmd.finish && cmd_set_r && (hit_r || !full);
  assign id_we     = cmd.finish && cmd_set_r && !hit_r && !full;

  always_comb begin
    out_word_nxt.weight_out = '0;
    out_word_nxt.found      = hit_r;
    out_word_nxt.status     = srwt_pkg::ST_OK;
    if (cmd_set_r == srwt_pkg::CMD_LOOKUP) begin
      if (hit_r) begin
        out_word_nxt.weight_out = hit_w_r;
      end
    end else if (!hit_r) begin
      out_word_nxt.status = full ? srwt_pkg::ST_FULL : srwt_pkg::ST_INSERTED;
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[wr_addr] <= val_r;
    end
    if (id_we) begin
      id_mem[wr_addr] <= key_r;
    end
    if (cmd.search && rd_more) begin
      rd_id_r <= id_mem[rd_addr];
      rd_w_r  <= w_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_set_r <= in_data.command;
      key_r     <= in_data.source_id[KEY_W-1:0];
      row_r     <= in_row;
      row_ok_r  <= in_row_ok;
      val_r     <= in_data.weight_value;
      base_r    <= ADDR_W'(32'(in_row) * 32'(MAX_CONNS));
    end
    if (cmd.search && hit_now) begin
      hit_idx_r <= cmp_idx_r;
      hit_w_r   <= rd_w_r;
    end
    if (cmd.search) begin
      cmp_idx_r <= rd_idx_r;
    end
    if (cmd.finish) begin
      out_word_r <= out_word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROW_N; i++) begin
        fill_r[i] <= '0;
      end
      cnt_r       <= '0;
      rd_idx_r    <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.load) begin
        cnt_r     <= in_row_ok ? fill_r[in_row] : '0;
        rd_idx_r  <= '0;
        cmp_vld_r <= 1'b0;
        hit_r     <= 1'b0;
      end else if (cmd.search) begin
        cmp_vld_r <= rd_more;
        if (rd_more) begin
          rd_idx_r <= rd_idx_r + CNT_W'(1);
        end
        if (hit_now) begin
          hit_r <= 1'b1;
        end
      end
      if (id_we) begin
        fill_r[row_r] <= cnt_r + CNT_W'(1);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule
